// ----- hdl/dns_question_parser_top_defines.svh -----
// Assertion macros for the DNS question parser.
`ifndef DNS_QUESTION_PARSER_TOP_DEFINES_SVH
`define DNS_QUESTION_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define DQP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dqp: same-cycle property violated");

// Next-cycle implication.
`define DQP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dqp: next-cycle property violated");

`endif

// ----- hdl/dqp_pkg.sv -----
// Shared constants and types of the DNS question parser.
`default_nettype none
package dqp_pkg;

   localparam int PKT_DEPTH_DEF = 512;
   localparam int MAX_JUMPS_DEF = 128;
   localparam int HEADER_BYTES  = 12;
   localparam int HDR_CAP       = 6;
   localparam int OFS_W         = 14;
   localparam int CSR_DATA_W    = 10;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_HEADER = 3'd1;
   localparam logic [2:0] ST_SHORT      = 3'd2;
   localparam logic [2:0] ST_TRUNC      = 3'd3;
   localparam logic [2:0] ST_LOOP       = 3'd4;
   localparam logic [2:0] ST_BAD_LABEL  = 3'd5;
   localparam logic [2:0] ST_LONG       = 3'd6;

   localparam logic CSR_MIN_QUERY_LEN = 1'b0;
   localparam logic CSR_MAX_LABEL_LEN = 1'b1;

   localparam logic [9:0] MIN_QUERY_LEN_RST = 10'd17;
   localparam logic [5:0] MAX_LABEL_LEN_RST = 6'd63;

   localparam logic [1:0] PTR_TAG  = 2'b11;
   localparam logic [9:0] WIRE_MAX = 10'h3FF;

   typedef struct packed {
      logic [9:0] min_query_len;
      logic [5:0] max_label_len;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] query_id;
      logic [15:0] hdr_flags;
      logic        qr_clear;
      logic [9:0]  qname_len;
      logic [15:0] qtype;
      logic [15:0] qclass;
      logic [9:0]  qsect_end;
   } rsp_type;

endpackage
`default_nettype wire

// ----- hdl/dqp_if.sv -----
// Channel interfaces: message bytes in, parse results out, register writes.
`default_nettype none
interface dqp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pkt_byte;
   logic       last;
   modport source (output valid, output pkt_byte, output last, input ready);
   modport sink (input valid, input pkt_byte, input last, output ready);
endinterface

interface dqp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] query_id;
   logic [15:0] hdr_flags;
   logic        qr_clear;
   logic [9:0]  qname_len;
   logic [15:0] qtype;
   logic [15:0] qclass;
   logic [9:0]  qsect_end;
   modport source (output valid, output status, output query_id, output hdr_flags,
                   output qr_clear, output qname_len, output qtype, output qclass,
                   output qsect_end, input ready);
   modport sink (input valid, input status, input query_id, input hdr_flags,
                 input qr_clear, input qname_len, input qtype, input qclass,
                 input qsect_end, output ready);
endinterface

interface dqp_csr_if;
   logic                            valid;
   logic                            ready;
   logic                            index;
   logic [dqp_pkg::CSR_DATA_W-1:0]  wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ----- hdl/dqp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dqp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = dqp_pkg::PKT_DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- hdl/dqp_ctrl.sv -----
// Message loader, header checks, name walk sequencer and result register.
`default_nettype none
module dqp_ctrl #(
   parameter int PKT_DEPTH = dqp_pkg::PKT_DEPTH_DEF,
   parameter int MAX_JUMPS = dqp_pkg::MAX_JUMPS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire dqp_pkg::cfg_type             cfg,
   dqp_req_if.sink                           req,
   dqp_rsp_if.source                         rsp,
   output logic                              ram_we,
   output logic [$clog2(PKT_DEPTH)-1:0]      ram_waddr,
   output logic [7:0]                        ram_wdata,
   output logic [$clog2(PKT_DEPTH)-1:0]      ram_raddr,
   input  wire logic [7:0]                   ram_rdata
);

   localparam int AW = $clog2(PKT_DEPTH);
   localparam int CW = $clog2(PKT_DEPTH + 1);
   localparam int TW = $clog2(MAX_JUMPS + 1);
   localparam int XW = dqp_pkg::OFS_W;
   localparam int HW = $clog2(dqp_pkg::HDR_CAP);

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_WALK  = 3'd2;
   localparam logic [2:0] S_LBYTE = 3'd3;
   localparam logic [2:0] S_PTR   = 3'd4;
   localparam logic [2:0] S_QRD   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [CW-1:0]    len_ff, len_in;
   logic [7:0]       hdr_ff [dqp_pkg::HDR_CAP];
   logic [CW-1:0]    walk_ff, walk_in;
   logic [CW-1:0]    resume_ff, resume_in;
   logic             jumped_ff, jumped_in;
   logic [TW-1:0]    tally_ff, tally_in;
   logic [9:0]       wire_ff, wire_in;
   logic [CW-1:0]    tail_ofs_ff, tail_ofs_in;
   logic [5:0]       ptr_hi_ff, ptr_hi_in;
   logic [2:0]       q_cnt_ff, q_cnt_in;
   logic [31:0]      q_ff, q_in;
   logic [2:0]       status_ff, status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   dqp_pkg::rsp_type rsp_ff, rsp_in;

   logic             acc;
   logic             full;
   logic             publish;
   logic [XW-1:0]    len_x;
   logic [XW-1:0]    ne_x;
   logic [XW-1:0]    lbl_end_x;
   logic [XW-1:0]    ptr_x;
   logic [XW-1:0]    qe_x;
   logic [10:0]      wire_lbl;
   logic [10:0]      wire_term;
   logic             ok;

   assign acc       = req.valid && req.ready;
   assign full      = count_ff == CW'(PKT_DEPTH);
   assign req.ready = state_ff == S_LOAD;
   assign ram_we    = acc && !full;
   assign ram_waddr = count_ff[AW-1:0];
   assign ram_wdata = req.pkt_byte;

   assign len_x     = XW'(len_ff);
   assign ne_x      = jumped_ff ? XW'(resume_ff) + XW'(2) : XW'(walk_ff) + XW'(1);
   assign lbl_end_x = XW'(walk_ff) + XW'(ram_rdata) + XW'(1);
   assign ptr_x     = {ptr_hi_ff, ram_rdata};
   assign qe_x      = XW'(tail_ofs_ff) + XW'(4);
   assign wire_lbl  = {1'b0, wire_ff} + 11'(ram_rdata) + 11'd1;
   assign wire_term = {1'b0, wire_ff} + 11'd1;
   assign publish   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp.ready);
   assign ok        = status_ff == dqp_pkg::ST_OK;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      len_in      = len_ff;
      walk_in     = walk_ff;
      resume_in   = resume_ff;
      jumped_in   = jumped_ff;
      tally_in    = tally_ff;
      wire_in     = wire_ff;
      tail_ofs_in = tail_ofs_ff;
      ptr_hi_in   = ptr_hi_ff;
      q_cnt_in    = q_cnt_ff;
      q_in        = q_ff;
      status_in   = status_ff;
      ram_raddr   = walk_ff[AW-1:0];
      case (state_ff)
         S_LOAD: begin
            if (acc) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + CW'(1);
               end
               if (req.last) begin
                  len_in   = full ? count_ff : count_ff + CW'(1);
                  ovf_in   = ovf_ff || full;
                  count_in = '0;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            ovf_in = 1'b0;
            if (ovf_ff) begin
               status_in = dqp_pkg::ST_LONG;
               state_in  = S_DONE;
            end else if (len_x < XW'(cfg.min_query_len) ||
                         len_x < XW'(dqp_pkg::HEADER_BYTES)) begin
               status_in = dqp_pkg::ST_SHORT;
               state_in  = S_DONE;
            end else if ({hdr_ff[4], hdr_ff[5]} == 16'd0) begin
               status_in = dqp_pkg::ST_BAD_HEADER;
               state_in  = S_DONE;
            end else begin
               walk_in   = CW'(dqp_pkg::HEADER_BYTES);
               resume_in = CW'(dqp_pkg::HEADER_BYTES);
               jumped_in = 1'b0;
               tally_in  = '0;
               wire_in   = '0;
               state_in  = S_WALK;
            end
         end
         S_WALK: begin
            if (tally_ff >= TW'(MAX_JUMPS)) begin
               status_in = dqp_pkg::ST_LOOP;
               state_in  = S_DONE;
            end else if (walk_ff >= len_ff) begin
               status_in = dqp_pkg::ST_TRUNC;
               state_in  = S_DONE;
            end else begin
               state_in = S_LBYTE;
            end
         end
         S_LBYTE: begin
            ram_raddr = walk_ff[AW-1:0] + AW'(1);
            if (ram_rdata == 8'd0) begin
               if (ne_x + XW'(4) > len_x) begin
                  status_in = dqp_pkg::ST_TRUNC;
                  state_in  = S_DONE;
               end else begin
                  tail_ofs_in = ne_x[CW-1:0];
                  wire_in     = wire_term[10] ? dqp_pkg::WIRE_MAX : wire_term[9:0];
                  q_cnt_in    = '0;
                  state_in    = S_QRD;
               end
            end else if (ram_rdata[7:6] == dqp_pkg::PTR_TAG) begin
               if (XW'(walk_ff) + XW'(1) >= len_x) begin
                  status_in = dqp_pkg::ST_TRUNC;
                  state_in  = S_DONE;
               end else begin
                  ptr_hi_in = ram_rdata[5:0];
                  state_in  = S_PTR;
               end
            end else if (ram_rdata > {2'b00, cfg.max_label_len}) begin
               status_in = dqp_pkg::ST_BAD_LABEL;
               state_in  = S_DONE;
            end else if (lbl_end_x > len_x) begin
               status_in = dqp_pkg::ST_TRUNC;
               state_in  = S_DONE;
            end else begin
               walk_in  = lbl_end_x[CW-1:0];
               wire_in  = wire_lbl[10] ? dqp_pkg::WIRE_MAX : wire_lbl[9:0];
               state_in = S_WALK;
            end
         end
         S_PTR: begin
            if (ptr_x >= len_x) begin
               status_in = dqp_pkg::ST_LOOP;
               state_in  = S_DONE;
            end else begin
               if (!jumped_ff) begin
                  resume_in = walk_ff;
                  jumped_in = 1'b1;
               end
               walk_in  = ptr_x[CW-1:0];
               tally_in = tally_ff + TW'(1);
               state_in = S_WALK;
            end
         end
         S_QRD: begin
            ram_raddr = tail_ofs_ff[AW-1:0] + AW'(q_cnt_ff[1:0]);
            if (q_cnt_ff != 3'd0) begin
               q_in = {q_ff[23:0], ram_rdata};
            end
            q_cnt_in = q_cnt_ff + 3'd1;
            if (q_cnt_ff == 3'd4) begin
               status_in = dqp_pkg::ST_OK;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (publish) begin
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (publish) begin
         rsp_valid_in = 1'b1;
      end
      rsp_in.status    = status_ff;
      rsp_in.query_id  = ok ? {hdr_ff[0], hdr_ff[1]} : 16'd0;
      rsp_in.hdr_flags = ok ? {hdr_ff[2], hdr_ff[3]} : 16'd0;
      rsp_in.qr_clear  = ok && !hdr_ff[2][7];
      rsp_in.qname_len = ok ? wire_ff : 10'd0;
      rsp_in.qtype     = ok ? q_ff[31:16] : 16'd0;
      rsp_in.qclass    = ok ? q_ff[15:0] : 16'd0;
      rsp_in.qsect_end = ok ? qe_x[9:0] : 10'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      walk_ff     <= walk_in;
      resume_ff   <= resume_in;
      jumped_ff   <= jumped_in;
      tally_ff    <= tally_in;
      wire_ff     <= wire_in;
      tail_ofs_ff <= tail_ofs_in;
      ptr_hi_ff   <= ptr_hi_in;
      q_cnt_ff    <= q_cnt_in;
      q_ff        <= q_in;
      status_ff   <= status_in;
      if (acc && count_ff < CW'(dqp_pkg::HDR_CAP)) begin
         hdr_ff[count_ff[HW-1:0]] <= req.pkt_byte;
      end
      if (publish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = rsp_ff.status;
   assign rsp.query_id  = rsp_ff.query_id;
   assign rsp.hdr_flags = rsp_ff.hdr_flags;
   assign rsp.qr_clear  = rsp_ff.qr_clear;
   assign rsp.qname_len = rsp_ff.qname_len;
   assign rsp.qtype     = rsp_ff.qtype;
   assign rsp.qclass    = rsp_ff.qclass;
   assign rsp.qsect_end = rsp_ff.qsect_end;

endmodule
`default_nettype wire

// ----- hdl/dns_question_parser_top.sv -----
// DNS question parser: top level with register file, packet RAM and control.
//
// req_ch carries a DNS message one byte per transfer, last set on its final
// byte. Bytes are written into a PKT_DEPTH-byte RAM at one per cycle, and the
// first six header bytes are also captured on the fly.
// After the last byte the block stops taking bytes and parses: a length/header
// check, then the name walk through the RAM, with states S_WALK and S_LBYTE
// per label or terminator and S_PTR as well per pointer (the RAM's read data
// is registered), then the reads of qtype and qclass and the result load.
// One result per message goes out on rsp_ch.
// Fields other than status are zero unless status is ok.
// The result sits in an output register; a new message may load while it
// waits, and only the next result stalls until rsp_ch takes the old one.
// csr_ch writes min_query_len (index 0) and max_label_len (index 1) and is
// always ready; write it only while the block is idle.
// Reset (synchronous) empties the message buffer and the result register and
// restores the register defaults 17 and 63; the RAM is not cleared.
`default_nettype none
`include "dns_question_parser_top_defines.svh"
module dns_question_parser_top #(
   parameter int PKT_DEPTH = dqp_pkg::PKT_DEPTH_DEF,
   parameter int MAX_JUMPS = dqp_pkg::MAX_JUMPS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   dqp_req_if.sink    req_ch,
   dqp_rsp_if.source  rsp_ch,
   dqp_csr_if.sink    csr_ch
);

   localparam int AW = $clog2(PKT_DEPTH);

   logic [9:0]       min_query_len_ff, min_query_len_in;
   logic [5:0]       max_label_len_ff, max_label_len_in;
   dqp_pkg::cfg_type cfg;

   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [7:0]       ram_wdata;
   logic [AW-1:0]    ram_raddr;
   logic [7:0]       ram_rdata;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      min_query_len_in = min_query_len_ff;
      max_label_len_in = max_label_len_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            dqp_pkg::CSR_MIN_QUERY_LEN: min_query_len_in = csr_ch.wdata[9:0];
            dqp_pkg::CSR_MAX_LABEL_LEN: max_label_len_in = csr_ch.wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_query_len_ff <= dqp_pkg::MIN_QUERY_LEN_RST;
         max_label_len_ff <= dqp_pkg::MAX_LABEL_LEN_RST;
      end else begin
         min_query_len_ff <= min_query_len_in;
         max_label_len_ff <= max_label_len_in;
      end
   end

   assign cfg.min_query_len = min_query_len_ff;
   assign cfg.max_label_len = max_label_len_ff;

   dqp_ram #(
      .WIDTH (8),
      .DEPTH (PKT_DEPTH)
   ) u_pkt_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   dqp_ctrl #(
      .PKT_DEPTH (PKT_DEPTH),
      .MAX_JUMPS (MAX_JUMPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   `DQP_ASSERT_NEXT(a_last_stops_input, req_ch.valid && req_ch.ready && req_ch.last, !req_ch.ready)
   `DQP_ASSERT_NOW(a_error_fields_zero, rsp_ch.valid && rsp_ch.status != dqp_pkg::ST_OK, rsp_ch.query_id == 16'd0 && rsp_ch.qtype == 16'd0 && rsp_ch.qsect_end == 10'd0)
   `DQP_ASSERT_NOW(a_ok_has_name, rsp_ch.valid && rsp_ch.status == dqp_pkg::ST_OK, rsp_ch.qname_len != 10'd0 && rsp_ch.qr_clear == !rsp_ch.hdr_flags[15])

endmodule
`default_nettype wire
